[rtl/ssbg_pkg.sv]
package ssbg_pkg;

    // Noise accumulator width and configuration register widths.
    localparam int SUM_W      = 56;
    localparam int OVS_W      = 10;
    localparam int MING_W     = 15;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Gain format: Q1.16, so the scale shift is 16.
    localparam int GAIN_W = 17;
    localparam int FRAC   = 16;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

    // The clean-to-signal ratio is a Q0.32 value that can reach 1.0, so 33 bits.
    localparam int RAT_W     = 33;
    localparam int RAT_SHIFT = 24;
    localparam int SQRT_STEPS = 17;

    // Noise mean divider: four quotient bits per stage.
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = SUM_W / DIV_BITS;

    // Split point and width of the oversubtraction product.
    localparam int SPLIT  = 32;
    localparam int PROD_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_OVERSUB   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_CNT = 2'd2;

    localparam logic [OVS_W-1:0]  OVERSUB_RST   = 10'd256;
    localparam logic [MING_W-1:0] MIN_GAIN_RST  = 15'd6554;
    localparam logic [CNT_W-1:0]  FRAME_CNT_RST = 8'd20;

endpackage

[rtl/spectral_subtraction_bin_gain.sv]
// Throughput: one request per cycle while the skid register is empty; the whole pipeline
// moves in lockstep on one advance enable.
// A training request updates its noise bin and produces no result.
// Reset (rst_n, asynchronous, active low) restores the registers to their defaults and then
// clears all FRAME_LEN/2+1 noise memory entries (257 by default); s_tready stays low meanwhile.
module spectral_subtraction_bin_gain #(
    parameter int FRAME_LEN   = 512,
    parameter int SAMPLE_BITS = 24,
    localparam int IDX_W      = $clog2(FRAME_LEN / 2 + 1),
    localparam int IN_W       = ((IDX_W + 2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((IDX_W + 2 * SAMPLE_BITS + ssbg_pkg::GAIN_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream, fields from bit 0: bin_index, bin_re, bin_im, zero fill.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_W-1:0]                 s_tdata,
    // kind: 0 trains the noise estimate, 1 asks for a denoised bin.
    input  logic                            s_tuser,
    // Output stream, fields from bit 0: out_index, out_re, out_im, gain_q16, zero fill.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_W-1:0]                m_tdata,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssbg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssbg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssbg_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int NBINS  = FRAME_LEN / 2 + 1;
    localparam int PW     = 2 * SB;
    localparam int SQ_W   = 2 * SB - 1;
    localparam int CW     = PW + 8;
    localparam int SIDE_W = IDX_W + 2 * SB;
    localparam int PH_W   = SUM_W - SPLIT + OVS_W;
    localparam int PL_W   = SPLIT + OVS_W;
    localparam int MUL_W  = SB + GAIN_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    logic [OVS_W-1:0]  oversub_reg;
    logic [MING_W-1:0] gain_floor_reg;
    logic [CNT_W-1:0]  frame_cnt_reg;
    logic [CNT_W-1:0]  cnt_eff;

    assign cfg_ready = 1'b1;
    // A frame count of zero divides by one.
    assign cnt_eff   = (frame_cnt_reg == '0) ? CNT_W'(1) : frame_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oversub_reg    <= OVERSUB_RST;
            gain_floor_reg <= MIN_GAIN_RST;
            frame_cnt_reg  <= FRAME_CNT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OVERSUB:   oversub_reg    <= cfg_data[OVS_W-1:0];
                REG_MIN_GAIN:  gain_floor_reg <= cfg_data[MING_W-1:0];
                REG_FRAME_CNT: frame_cnt_reg  <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The skid register at the output holds one result so that
    // s_tready and the pipeline enable come from a flop, not from m_tready.
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic skid_valid_reg;
    logic clearing_reg;
    logic adv;
    logic accept;

    assign adv      = !skid_valid_reg;
    assign s_tready = !skid_valid_reg && !clearing_reg;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Noise sum memory with a clearing pass after reset.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] noise_mem [0:NBINS-1];
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [SUM_W-1:0] rd_reg;
    logic [IDX_W-1:0] in_idx;
    logic             in_ok;
    logic             mem_we;
    logic [IDX_W-1:0] wr_idx;
    logic [SUM_W-1:0] wr_sum;

    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_ok  = (in_idx < IDX_W'(NBINS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == IDX_W'(NBINS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            noise_mem[clr_cnt_reg] <= '0;
        end
        else if (mem_we)
        begin
            noise_mem[wr_idx] <= wr_sum;
        end
        if (adv)
        begin
            rd_reg <= noise_mem[in_ok ? in_idx : '0];
        end
    end

    // ------------------------------------------------------------------
    // Stage A: capture the request. The memory read is issued at the same edge.
    // ------------------------------------------------------------------
    logic                 a_valid_reg;
    logic                 a_kind_reg;
    logic                 a_ok_reg;
    logic [IDX_W-1:0]     a_idx_reg;
    logic signed [SB-1:0] a_re_reg;
    logic signed [SB-1:0] a_im_reg;
    logic signed [PW-1:0] a_sq_re;
    logic signed [PW-1:0] a_sq_im;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_kind_reg <= s_tuser;
            a_ok_reg   <= in_ok;
            a_idx_reg  <= in_idx;
            a_re_reg   <= s_tdata[IDX_W +: SB];
            a_im_reg   <= s_tdata[IDX_W+SB +: SB];
        end
    end

    assign a_sq_re = a_re_reg * a_re_reg;
    assign a_sq_im = a_im_reg * a_im_reg;

    // ------------------------------------------------------------------
    // Stage B: squares registered.
    // ------------------------------------------------------------------
    logic                 b_valid_reg;
    logic                 b_kind_reg;
    logic                 b_ok_reg;
    logic [IDX_W-1:0]     b_idx_reg;
    logic [SB-1:0]        b_re_reg;
    logic [SB-1:0]        b_im_reg;
    logic [SQ_W-1:0]      b_sq_re_reg;
    logic [SQ_W-1:0]      b_sq_im_reg;
    logic [SUM_W-1:0]     b_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_kind_reg  <= a_kind_reg;
            b_ok_reg    <= a_ok_reg;
            b_idx_reg   <= a_idx_reg;
            b_re_reg    <= a_re_reg;
            b_im_reg    <= a_im_reg;
            b_sq_re_reg <= a_sq_re[SQ_W-1:0];
            b_sq_im_reg <= a_sq_im[SQ_W-1:0];
            b_rd_reg    <= rd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C logic: power, forwarding, saturating accumulate and write-back.
    // The two training updates just ahead of this request were not yet in
    // memory when it was read, so they are forwarded from a short history.
    // ------------------------------------------------------------------
    logic             h_we_reg  [0:1];
    logic [IDX_W-1:0] h_idx_reg [0:1];
    logic [SUM_W-1:0] h_sum_reg [0:1];
    logic [PW-1:0]    c_power;
    logic [SUM_W-1:0] c_base;
    logic [SUM_W:0]   c_acc;
    logic             c_train;

    assign c_power = PW'(b_sq_re_reg) + PW'(b_sq_im_reg);
    assign c_base  = (h_we_reg[0] && h_idx_reg[0] == b_idx_reg) ? h_sum_reg[0] :
                     (h_we_reg[1] && h_idx_reg[1] == b_idx_reg) ? h_sum_reg[1] : b_rd_reg;
    assign c_acc   = {1'b0, c_base} + (SUM_W+1)'(c_power);
    assign c_train = b_valid_reg && !b_kind_reg && b_ok_reg;
    assign wr_sum  = c_acc[SUM_W] ? {SUM_W{1'b1}} : c_acc[SUM_W-1:0];
    assign wr_idx  = b_idx_reg;
    assign mem_we  = adv && c_train;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_we_reg[0] <= 1'b0;
            h_we_reg[1] <= 1'b0;
        end
        else if (adv)
        begin
            h_we_reg[0] <= c_train;
            h_we_reg[1] <= h_we_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_idx_reg[0] <= b_idx_reg;
            h_sum_reg[0] <= wr_sum;
            h_idx_reg[1] <= h_idx_reg[0];
            h_sum_reg[1] <= h_sum_reg[0];
        end
    end

    // ------------------------------------------------------------------
    // Noise mean: noise sum divided by the frame count, four bits a stage.
    // Only denoise requests travel on from here as valid.
    // ------------------------------------------------------------------
    logic              dv_valid [0:DIV_STAGES];
    logic [SUM_W-1:0]  dv_num   [0:DIV_STAGES];
    logic [CNT_W-1:0]  dv_rem   [0:DIV_STAGES];
    logic [PW-1:0]     dv_pw    [0:DIV_STAGES];
    logic [SIDE_W-1:0] dv_side  [0:DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid[0] <= b_valid_reg && b_kind_reg;
        end
    end

    // An out-of-range bin uses a noise mean of zero.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_num[0]  <= b_ok_reg ? c_base : '0;
            dv_rem[0]  <= '0;
            dv_pw[0]   <= c_power;
            dv_side[0] <= {b_im_reg, b_re_reg, b_idx_reg};
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [SUM_W-1:0] n_next;
        logic [CNT_W-1:0] r_next;

        always_comb
        begin
            logic [CNT_W:0] t;
            n_next = dv_num[k];
            r_next = dv_rem[k];
            for (int j = 0; j < DIV_BITS; j++)
            begin
                t      = {r_next, n_next[SUM_W-1]};
                n_next = {n_next[SUM_W-2:0], 1'b0};
                if (t >= {1'b0, cnt_eff})
                begin
                    r_next    = CNT_W'(t - {1'b0, cnt_eff});
                    n_next[0] = 1'b1;
                end
                else
                begin
                    r_next = t[CNT_W-1:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid[k+1] <= dv_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_num[k+1]  <= n_next;
                dv_rem[k+1]  <= r_next;
                dv_pw[k+1]   <= dv_pw[k];
                dv_side[k+1] <= dv_side[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Oversubtraction: multiply in two halves, combine, subtract from S*256.
    // A product at or beyond 2^63 makes the clean power zero.
    // ------------------------------------------------------------------
    logic              m1_valid_reg, m2_valid_reg, m3_valid_reg;
    logic [PH_W-1:0]   m1_ph_reg;
    logic [PL_W-1:0]   m1_pl_reg;
    logic [PW-1:0]     m1_pw_reg, m2_pw_reg, m3_pw_reg;
    logic [SIDE_W-1:0] m1_side_reg, m2_side_reg, m3_side_reg;
    logic              m2_big_reg;
    logic [PROD_W-1:0] m2_prod_reg;
    logic [CW-1:0]     m3_clean_reg;
    logic [PROD_W-1:0] s8_ext;

    assign s8_ext = PROD_W'({m2_pw_reg, 8'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg <= dv_valid[DIV_STAGES];
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_ph_reg    <= dv_num[DIV_STAGES][SUM_W-1:SPLIT] * oversub_reg;
            m1_pl_reg    <= dv_num[DIV_STAGES][SPLIT-1:0] * oversub_reg;
            m1_pw_reg    <= dv_pw[DIV_STAGES];
            m1_side_reg  <= dv_side[DIV_STAGES];
            m2_big_reg   <= (m1_ph_reg[PH_W-1:SPLIT-1] != '0);
            m2_prod_reg  <= PROD_W'({m1_ph_reg, {SPLIT{1'b0}}}) + PROD_W'(m1_pl_reg);
            m2_pw_reg    <= m1_pw_reg;
            m2_side_reg  <= m1_side_reg;
            m3_clean_reg <= (!m2_big_reg && s8_ext > m2_prod_reg) ?
                            CW'(s8_ext - m2_prod_reg) : '0;
            m3_pw_reg    <= m2_pw_reg;
            m3_side_reg  <= m2_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Gain: ratio divider, square root and floor.
    // ------------------------------------------------------------------
    logic              g_valid;
    logic [GAIN_W-1:0] g_gain;
    logic [SIDE_W-1:0] g_side;

    ssbg_gain #(
        .PW     (PW),
        .SIDE_W (SIDE_W)
    ) u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (m3_valid_reg),
        .in_clean   (m3_clean_reg),
        .in_power   (m3_pw_reg),
        .in_side    (m3_side_reg),
        .gain_floor (gain_floor_reg),
        .out_valid  (g_valid),
        .out_gain   (g_gain),
        .out_side   (g_side)
    );

    // ------------------------------------------------------------------
    // Scale stage. An arithmetic shift of the product gives the floor.
    // ------------------------------------------------------------------
    logic                    sc_valid_reg;
    logic [IDX_W-1:0]        sc_idx_reg;
    logic [GAIN_W-1:0]       sc_gain_reg;
    logic signed [MUL_W-1:0] sc_re_reg;
    logic signed [MUL_W-1:0] sc_im_reg;
    logic signed [SB-1:0]    g_re;
    logic signed [SB-1:0]    g_im;
    logic signed [GAIN_W:0]  g_gain_s;
    logic [OUT_W-1:0]        res_data;

    assign g_re     = g_side[IDX_W +: SB];
    assign g_im     = g_side[IDX_W+SB +: SB];
    assign g_gain_s = {1'b0, g_gain};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sc_valid_reg <= g_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_idx_reg  <= g_side[IDX_W-1:0];
            sc_gain_reg <= g_gain;
            sc_re_reg   <= g_re * g_gain_s;
            sc_im_reg   <= g_im * g_gain_s;
        end
    end

    assign res_data = OUT_W'({sc_gain_reg, sc_im_reg[FRAC +: SB], sc_re_reg[FRAC +: SB],
                              sc_idx_reg});

    // ------------------------------------------------------------------
    // Output register and skid register.
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic             res_push;

    assign res_push = sc_valid_reg && adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_push;
            end
        end
        else if (res_push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
        end
        else if (res_push)
        begin
            skid_data_reg <= res_data;
        end
    end

`ifndef SYNTHESIS
    // No request may enter while the noise memory is being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_tready)
        else $error("request accepted during memory clear");

    // The skid register only fills behind a held output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register valid without output valid");

    // A delivered gain lies between the floor and unity.
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[SIDE_W +: GAIN_W] >= GAIN_W'(gain_floor_reg)) &&
                          (out_data_reg[SIDE_W +: GAIN_W] <= GAIN_ONE))
        else $error("gain outside floor and unity");

    // Pipeline write-back never collides with the clearing pass.
    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !mem_we)
        else $error("noise write during memory clear");
`endif

endmodule

[rtl/ssbg_gain.sv]
module ssbg_gain #(
    parameter int PW     = 48,
    parameter int SIDE_W = 57
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic [PW+7:0]                  in_clean,
    input  logic [PW-1:0]                  in_power,
    input  logic [SIDE_W-1:0]              in_side,
    input  logic [ssbg_pkg::MING_W-1:0]    gain_floor,
    output logic                           out_valid,
    output logic [ssbg_pkg::GAIN_W-1:0]    out_gain,
    output logic [SIDE_W-1:0]              out_side
);
    import ssbg_pkg::*;

    localparam int SQ_X_W = 2 * SQRT_STEPS;
    localparam int RW     = GAIN_W + 3;

    // Ratio divider: floor(clean * 2^24 / power), one quotient bit per stage.
    logic              rv  [0:RAT_W];
    logic              rz  [0:RAT_W];
    logic [PW-1:0]     rs  [0:RAT_W];
    logic [PW-1:0]     rr  [0:RAT_W];
    logic [RAT_W-1:0]  rn  [0:RAT_W];
    logic [SIDE_W-1:0] rsd [0:RAT_W];

    assign rv[0]  = in_valid;
    assign rz[0]  = (in_power == '0);
    assign rs[0]  = in_power;
    assign rr[0]  = PW'(in_clean >> (RAT_W - RAT_SHIFT));
    assign rn[0]  = {in_clean[RAT_W-RAT_SHIFT-1:0], {RAT_SHIFT{1'b0}}};
    assign rsd[0] = in_side;

    for (genvar k = 0; k < RAT_W; k++) begin : g_rat
        logic [PW:0] trial;
        logic        take;

        assign trial = {rr[k], rn[k][RAT_W-1]};
        assign take  = (trial >= {1'b0, rs[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rv[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                rv[k+1] <= rv[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rz[k+1]  <= rz[k];
                rs[k+1]  <= rs[k];
                rr[k+1]  <= take ? PW'(trial - {1'b0, rs[k]}) : PW'(trial);
                rn[k+1]  <= {rn[k][RAT_W-2:0], take};
                rsd[k+1] <= rsd[k];
            end
        end
    end

    // Integer square root, one result bit per stage.
    logic              sv  [0:SQRT_STEPS];
    logic              sz  [0:SQRT_STEPS];
    logic [SQ_X_W-1:0] sx  [0:SQRT_STEPS];
    logic [RW-1:0]     srm [0:SQRT_STEPS];
    logic [GAIN_W-1:0] srt [0:SQRT_STEPS];
    logic [SIDE_W-1:0] ssd [0:SQRT_STEPS];

    assign sv[0]  = rv[RAT_W];
    assign sz[0]  = rz[RAT_W];
    assign sx[0]  = SQ_X_W'(rn[RAT_W]);
    assign srm[0] = '0;
    assign srt[0] = '0;
    assign ssd[0] = rsd[RAT_W];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [RW-1:0] r2;
        logic [RW-1:0] t;
        logic          take;

        assign r2   = {srm[k][RW-3:0], sx[k][SQ_X_W-1 -: 2]};
        assign t    = {1'b0, srt[k], 2'b01};
        assign take = (r2 >= t);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sv[k+1] <= sv[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sz[k+1]  <= sz[k];
                sx[k+1]  <= {sx[k][SQ_X_W-3:0], 2'b00};
                srm[k+1] <= take ? (r2 - t) : r2;
                srt[k+1] <= {srt[k][GAIN_W-2:0], take};
                ssd[k+1] <= ssd[k];
            end
        end
    end

    // Zero power gives a raw gain of zero; then the floor applies.
    logic [GAIN_W-1:0] raw_gain;
    logic [GAIN_W-1:0] floor_gain;

    assign raw_gain   = sz[SQRT_STEPS] ? '0 :
                        ((srt[SQRT_STEPS] > GAIN_ONE) ? GAIN_ONE : srt[SQRT_STEPS]);
    assign floor_gain = (raw_gain < GAIN_W'(gain_floor)) ? GAIN_W'(gain_floor) : raw_gain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= sv[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_gain <= floor_gain;
            out_side <= ssd[SQRT_STEPS];
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

// Checks the spectral subtraction gain stage: noise training requests accumulate per-bin
// power, denoise requests come back scaled by the computed gain. A behavioral gain
// predictor runs beside the block and every output request is compared field by field.
module testbench;
    import ssbg_pkg::*;

    localparam int IN_W  = 64;
    localparam int OUT_W = 80;
    localparam int NBINS = 257;
    localparam logic KIND_TRAIN   = 1'b0;
    localparam logic KIND_DENOISE = 1'b1;
    // Index 3 is not a register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 90;
    localparam int STALL_LIMIT   = 5000;
    localparam longint unsigned SUM_SAT = (64'd1 << SUM_W) - 1;

    typedef struct packed {
        logic [8:0]        idx;
        logic [23:0]       re;
        logic [23:0]       im;
        logic [GAIN_W-1:0] gain;
    } bin_result_t;

    // A directed row; when known is set, the expected result is typed in below.
    typedef struct {
        logic              kind;
        logic [8:0]        idx;
        logic [23:0]       re;
        logic [23:0]       im;
        bit                known;
        logic [23:0]       e_re;
        logic [23:0]       e_im;
        logic [GAIN_W-1:0] e_gain;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    spectral_subtraction_bin_gain dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Predictor state: its own copy of the registers and the noise memory.
    logic [OVS_W-1:0]  oversub = OVERSUB_RST;
    logic [MING_W-1:0] gain_floor = MIN_GAIN_RST;
    logic [CNT_W-1:0]  frame_cnt = FRAME_CNT_RST;
    longint unsigned   noise_acc [NBINS];

    bin_result_t pending_bins [$];
    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned bin_power(logic [23:0] re, logic [23:0] im);
        longint signed r;
        longint signed i;
        r = longint'($signed(re));
        i = longint'($signed(im));
        return longint'(r * r + i * i);
    endfunction

    // Training adds the bin power into the saturating per-bin sum; bad bins are dropped.
    function automatic void train_noise(logic [8:0] idx, logic [23:0] re, logic [23:0] im);
        longint unsigned t;
        if (idx < NBINS)
        begin
            t = noise_acc[idx] + bin_power(re, im);
            noise_acc[idx] = (t > SUM_SAT) ? SUM_SAT : t;
        end
    endfunction

    function automatic bin_result_t denoise_bin(logic [8:0] idx, logic [23:0] re,
                                                logic [23:0] im);
        longint unsigned s, cnt, n, s8, ph, pl, clean, q, rem, g;
        longint signed pr, pi;
        bin_result_t r;
        s = bin_power(re, im);
        cnt = (frame_cnt == 0) ? 1 : frame_cnt;
        n = (idx < NBINS) ? noise_acc[idx] / cnt : 0;
        s8 = s << 8;
        ph = (n >> 32) * oversub;
        pl = (n & 64'hFFFF_FFFF) * oversub;
        clean = 0;
        // A noise product past 2^63 leaves no clean power.
        if (ph < (64'd1 << 31) && s8 > (ph << 32) + pl)
            clean = s8 - ((ph << 32) + pl);
        g = 0;
        if (s != 0)
        begin
            q = clean / s;
            rem = clean % s;
            for (int k = 0; k < RAT_SHIFT; k++)
            begin
                rem <<= 1;
                q <<= 1;
                if (rem >= s)
                begin
                    rem -= s;
                    q |= 1;
                end
            end
            g = int_sqrt(q);
            if (g > GAIN_ONE)
                g = GAIN_ONE;
        end
        if (g < gain_floor)
            g = gain_floor;
        pr = longint'($signed(re)) * longint'(g);
        pi = longint'($signed(im)) * longint'(g);
        r.idx = idx;
        r.re = 24'(pr >>> FRAC);
        r.im = 24'(pi >>> FRAC);
        r.gain = GAIN_W'(g);
        return r;
    endfunction

    // The receiver stalls at the rate of the current phase.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Output checker: every accepted request pairs with the oldest expectation.
    always @(posedge clk)
    begin
        bin_result_t got;
        bin_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[8:0], m_tdata[32:9], m_tdata[56:33], m_tdata[73:57]};
            if (pending_bins.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, actual %h", $time, got);
            end
            else
            begin
                want = pending_bins.pop_front();
                if (got.idx !== want.idx)
                begin
                    errors++;
                    $display("%0t out_index: expected %0d, actual %0d", $time, want.idx,
                             got.idx);
                end
                if (got.re !== want.re)
                begin
                    errors++;
                    $display("%0t out_re: expected %h, actual %h", $time, want.re, got.re);
                end
                if (got.im !== want.im)
                begin
                    errors++;
                    $display("%0t out_im: expected %h, actual %h", $time, want.im, got.im);
                end
                if (got.gain !== want.gain)
                begin
                    errors++;
                    $display("%0t gain_q16: expected %0d, actual %0d", $time, want.gain,
                             got.gain);
                end
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Sends one bin request. A denoise request with known set uses the typed expectation.
    task automatic send_bin(logic kind, logic [8:0] idx, logic [23:0] re, logic [23:0] im,
                            bit known = 1'b0, bin_result_t typed = '0);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {7'd0, im, re, idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == KIND_TRAIN)
            train_noise(idx, re, im);
        else
            pending_bins.push_back(known ? typed : denoise_bin(idx, re, im));
    endtask

    // Register writes happen only once the pipeline has drained.
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        s_tvalid <= 1'b0;
        wait (pending_bins.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            REG_OVERSUB:   oversub = value[OVS_W-1:0];
            REG_MIN_GAIN:  gain_floor = value[MING_W-1:0];
            REG_FRAME_CNT: frame_cnt = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // A sample of random magnitude; a shift of zero exercises every bit.
    function automatic logic [23:0] rand_sample(int sh);
        logic signed [23:0] v;
        v = 24'($urandom);
        return v >>> sh;
    endfunction

    dir_row_t directed [] = '{
        // Zero power with an empty noise memory: the gain sits on the floor.
        '{KIND_DENOISE, 9'd0, 24'd0, 24'd0, 1'b1, 24'd0, 24'd0, 17'd6554},
        // No noise learned yet: unity gain passes full scale through unchanged.
        '{KIND_DENOISE, 9'd256, 24'h7FFFFF, 24'h800000, 1'b1, 24'h7FFFFF, 24'h800000,
          17'd65536},
        // An out-of-range bin always sees zero noise.
        '{KIND_DENOISE, 9'd511, 24'hFFFFFF, 24'd1, 1'b1, 24'hFFFFFF, 24'd1, 17'd65536},
        '{KIND_TRAIN, 9'd511, 24'h7FFFFF, 24'h7FFFFF, 1'b0, '0, '0, '0},
        '{KIND_DENOISE, 9'd511, 24'd5, 24'd0, 1'b1, 24'd5, 24'd0, 17'd65536},
        '{KIND_TRAIN, 9'd3, 24'd1000, 24'hFFF830, 1'b0, '0, '0, '0},
        '{KIND_TRAIN, 9'd3, 24'd1500, 24'd800, 1'b0, '0, '0, '0},
        '{KIND_DENOISE, 9'd3, 24'd1000, 24'hFFF830, 1'b0, '0, '0, '0},
        '{KIND_DENOISE, 9'd3, 24'd100, 24'd0, 1'b0, '0, '0, '0},
        '{KIND_DENOISE, 9'd3, 24'h800000, 24'd0, 1'b0, '0, '0, '0},
        '{KIND_DENOISE, 9'd3, 24'd0, 24'd0, 1'b1, 24'd0, 24'd0, 17'd6554},
        '{KIND_TRAIN, 9'd256, 24'h800000, 24'h800000, 1'b0, '0, '0, '0},
        '{KIND_DENOISE, 9'd256, 24'h7FFFFF, 24'h7FFFFF, 1'b0, '0, '0, '0},
        '{KIND_DENOISE, 9'd256, 24'hFFFFFF, 24'h000001, 1'b0, '0, '0, '0},
        '{KIND_TRAIN, 9'd0, 24'd1, 24'd0, 1'b0, '0, '0, '0},
        '{KIND_DENOISE, 9'd0, 24'd1, 24'd0, 1'b0, '0, '0, '0},
        '{KIND_DENOISE, 9'd257, 24'h555555, 24'hAAAAAA, 1'b0, '0, '0, '0}
    };

    // Register settings per phase: oversubtraction, floor, frame count.
    int unsigned phase_cfg [][3] = '{
        '{256, 0, 1}, '{512, 19661, 255}, '{1023, 32767, 0}, '{384, 3277, 4},
        '{256, 6554, 20}, '{700, 1, 2}
    };

    initial
    begin
        bin_result_t typed;
        logic [8:0] pool [4];
        int nsh, psh;
        for (int b = 0; b < NBINS; b++)
            noise_acc[b] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows run with reset registers and no idling.
        foreach (directed[i])
        begin
            typed = '{directed[i].idx, directed[i].e_re, directed[i].e_im, directed[i].e_gain};
            send_bin(directed[i].kind, directed[i].idx, directed[i].re, directed[i].im,
                     directed[i].known, typed);
        end

        write_reg(REG_NONE, 15'h7FFF);
        foreach (phase_cfg[p])
        begin
            write_reg(REG_OVERSUB, CFG_DATA_W'(phase_cfg[p][0]));
            write_reg(REG_MIN_GAIN, CFG_DATA_W'(phase_cfg[p][1]));
            write_reg(REG_FRAME_CNT, CFG_DATA_W'(phase_cfg[p][2]));
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            // A handful of bins is trained and then denoised, with stray requests mixed in.
            for (int k = 0; k < 4; k++)
                pool[k] = (k == 3 && $urandom_range(1)) ? 9'($urandom_range(257, 511))
                                                        : 9'($urandom_range(0, 256));
            nsh = $urandom_range(0, 14);
            for (int n = 0; n < 90; n++)
            begin
                logic [8:0] idx;
                idx = ($urandom_range(99) < 85) ? pool[$urandom_range(3)]
                                                : 9'($urandom_range(0, 511));
                if (n < 40 || $urandom_range(99) < 25)
                    send_bin(KIND_TRAIN, idx, rand_sample(nsh), rand_sample(nsh));
                else
                begin
                    psh = nsh + $urandom_range(0, 6) - 3;
                    psh = (psh < 0) ? 0 : (psh > 23 ? 23 : psh);
                    send_bin(KIND_DENOISE, idx, rand_sample(psh), rand_sample(psh));
                end
            end
        end

        // Saturate one bin so that the oversubtracted product runs out of range.
        idle_pct = 0;
        stall_pct = 30;
        write_reg(REG_FRAME_CNT, CFG_DATA_W'(1));
        for (int n = 0; n < 520; n++)
            send_bin(KIND_TRAIN, 9'd7, 24'h800000, 24'h800000);
        for (int n = 0; n < 30; n++)
            send_bin(KIND_DENOISE, 9'd7, rand_sample($urandom_range(0, 4)),
                     rand_sample($urandom_range(0, 4)));

        s_tvalid <= 1'b0;
        wait (pending_bins.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
